>>> sv/tprq_pkg.sv
// package: shared types and constants of the transmit priority queue
package tprq_pkg;
	localparam int QueueDepthDef = 16;
	localparam int NodeCountDef  = 16;

	localparam logic [2:0] FUNC_ADD    = 3'd0;
	localparam logic [2:0] FUNC_GET    = 3'd1;
	localparam logic [2:0] FUNC_MARK   = 3'd2;
	localparam logic [2:0] FUNC_REMOVE = 3'd3;
	localparam logic [2:0] FUNC_CLEAR  = 3'd4;

	localparam logic [3:0] DEST_MASK = 4'h0F;

	// one stored descriptor
	typedef struct packed {
		logic        valid;
		logic [2:0]  prio;
		logic [3:0]  dest;
		logic [7:0]  number;
		logic        number_set;
		logic [7:0]  sent_count;
		logic [31:0] sent_time;
		logic [31:0] timeout;
		logic [7:0]  retry_limit;
		logic        qos;
		logic [7:0]  tag;
	} entry_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic        insert;   // insert phase active
		logic        remove;   // shift-up phase active
		logic        mark;     // at-least-once mark
		logic        number;   // assign number to selected cell
		logic        clear;
		logic [31:0] now;
		logic [7:0]  num_val;
	} cell_ctrl_t;

	// per-cell status toward the sequencer
	typedef struct packed {
		logic valid;
		logic ge_prio;   // stored priority >= requested
		logic expired;   // timeout elapsed
		logic spent;     // sent count above limit
		logic sent;      // sent count non-zero
		logic match;     // numbered entry with dest/number match
	} cell_stat_t;
endpackage

>>> sv/tprq_if.sv
// interfaces: request and result channels
interface tprq_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [31:0] now_ms;
	logic [2:0]  priority_req;
	logic [3:0]  dest_id;
	logic        number_preset;
	logic [7:0]  pkt_number;
	logic [31:0] timeout_ms;
	logic [7:0]  max_retry;
	logic        qos;
	logic [7:0]  tag;
	modport source (output valid, func, now_ms, priority_req, dest_id, number_preset,
		pkt_number, timeout_ms, max_retry, qos, tag, input ready);
	modport sink (input valid, func, now_ms, priority_req, dest_id, number_preset,
		pkt_number, timeout_ms, max_retry, qos, tag, output ready);
endinterface

interface tprq_rsp_if;
	logic       valid;
	logic       ready;
	logic       ok;
	logic [7:0] tag_out;
	logic [3:0] dest_out;
	logic [7:0] number_out;
	logic       is_retry;
	logic       dropped;
	modport source (output valid, ok, tag_out, dest_out, number_out, is_retry, dropped,
		input ready);
	modport sink (input valid, ok, tag_out, dest_out, number_out, is_retry, dropped,
		output ready);
endinterface

>>> sv/tprq_cell.sv
// cell: one queue slot, shifts toward its neighbors on insert and removal
module tprq_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tprq_pkg::cell_ctrl_t  ctrl,
	input  logic                  sel,        // this cell is the target
	input  logic                  take_prev,  // insert: take the entry above
	input  logic                  take_next,  // removal: take the entry below
	input  tprq_pkg::entry_t      new_entry,
	input  tprq_pkg::entry_t      prev_entry,
	input  tprq_pkg::entry_t      next_entry,
	input  logic [2:0]            req_prio,
	input  logic [3:0]            req_dest,
	input  logic [7:0]            req_number,
	output tprq_pkg::entry_t      entry,
	output tprq_pkg::cell_stat_t  stat
);
	import tprq_pkg::*;

	// payload bits of an entry, everything below the valid flag
	localparam int PW = $bits(entry_t) - 1;

	logic          valid_q;
	logic [PW-1:0] pay_q;
	entry_t        cur;
	entry_t        nxt;
	logic [31:0]   age;

	assign cur   = {valid_q, pay_q};
	assign entry = cur;
	assign age   = ctrl.now - cur.sent_time;

	// status compares
	always_comb begin
		stat.valid   = cur.valid;
		stat.ge_prio = cur.prio >= req_prio;
		stat.expired = age >= cur.timeout;
		stat.spent   = cur.sent_count > cur.retry_limit;
		stat.sent    = cur.sent_count != 8'd0;
		stat.match   = cur.valid && cur.number_set && cur.number == req_number
			&& cur.dest == req_dest;
	end

	// next slot contents
	always_comb begin
		nxt = cur;
		if (ctrl.insert && sel) begin
			nxt = new_entry;
		end else if (ctrl.insert && take_prev) begin
			nxt = prev_entry;
		end else if (ctrl.remove && take_next) begin
			nxt = next_entry;
		end else if (ctrl.mark && sel) begin
			if (cur.sent_count != 8'hFF) begin
				nxt.sent_count = cur.sent_count + 8'd1;
			end
			nxt.sent_time = ctrl.now;
		end else if (ctrl.number && sel) begin
			nxt.number     = ctrl.num_val;
			nxt.number_set = 1'b1;
		end
		if (ctrl.clear) begin
			nxt.valid = 1'b0;
		end
	end

	// payload fields
	always_ff @(posedge clk) begin
		pay_q <= nxt[PW-1:0];
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end
endmodule

>>> sv/tx_priority_retry_queue_top.sv
// top level: transmit priority queue with retry handling
//
// One request channel (req) carries an operation and its fields, one result
// channel (rsp) returns one result per request. Operations: add, get_next,
// mark_sent, remove and clear. The queue is a row of cells, slot 0 holding the
// highest priority; cells compare in parallel and shift by one slot to their
// neighbor on insertion or removal.
// Add, mark_sent, remove and clear run an evaluation step and then an action
// step before presenting their result; get_next runs a drop pass, a shift
// step, then a selection pass before its action step. One request is in
// flight at a time and the request side is ready again in the cycle after
// the result is taken.
// A finished result waits in the output register until taken; while it
// waits the next request is not accepted.
// Reset empties the queue and zeroes the per-destination number counters.
module tx_priority_retry_queue_top #(
	parameter int QUEUE_DEPTH = tprq_pkg::QueueDepthDef,
	parameter int NODE_COUNT  = tprq_pkg::NodeCountDef
) (
	input  logic clk,
	input  logic arst_n,
	tprq_req_if.sink   req,
	tprq_rsp_if.source rsp
);
	import tprq_pkg::*;

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EVAL = 3'd1;
	localparam logic [2:0] ST_SEL  = 3'd2;
	localparam logic [2:0] ST_ACT  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;
	localparam logic [2:0] ST_DROP = 3'd5;

	logic [2:0] state_q;

	// latched request
	logic [2:0]  func_q;
	logic [31:0] now_q;
	logic [2:0]  prio_q;
	logic [3:0]  dest_q;
	logic        preset_q;
	logic [7:0]  pnum_q;
	logic [31:0] tmo_q;
	logic [7:0]  maxr_q;
	logic        qos_q;
	logic [7:0]  tag_q;

	// result register
	logic       ok_q, retry_q, drop_q;
	logic [7:0] tag_out_q, num_out_q;
	logic [3:0] dest_out_q;

	// chosen cell and action
	logic [IW-1:0] idx_q;
	logic          hit_q;
	logic          act_ins_q, act_rem_q, act_mark_q, act_num_q, act_clr_q;

	logic [7:0] next_number_q [NODE_COUNT];

	entry_t     entries [QUEUE_DEPTH];
	cell_stat_t stats   [QUEUE_DEPTH];
	cell_ctrl_t ctrl;
	entry_t     new_entry;
	entry_t     empty_entry;

	logic [QUEUE_DEPTH-1:0] v_vec, ge_vec, drop_vec, match_vec, pick_vec;
	logic [NW-1:0] cidx;
	logic [NW-1:0] dest_mod [16];

	// per-cell flag vectors
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			v_vec[i]     = stats[i].valid;
			ge_vec[i]    = stats[i].valid && stats[i].ge_prio;
			drop_vec[i]  = stats[i].valid && stats[i].expired && stats[i].spent;
			match_vec[i] = stats[i].match;
			pick_vec[i]  = stats[i].valid && (stats[i].sent ?
				(stats[i].expired && !stats[i].spent) : 1'b1);
		end
	end

	// first-set search over a flag vector
	function automatic logic [IW:0] first_set(input logic [QUEUE_DEPTH-1:0] v);
		logic [IW:0] r;
		r = '1;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = {1'b0, IW'(i)};
			end
		end
		return r;
	endfunction

	// insertion point: count of leading cells with priority >= request
	logic [IW:0] ins_pos;
	always_comb begin
		ins_pos = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (ge_vec[i]) begin
				ins_pos = (IW + 1)'(i + 1);
			end
		end
	end

	logic [IW:0] f_drop, f_match, f_pick;
	assign f_drop  = first_set(drop_vec);
	assign f_match = first_set(match_vec);
	assign f_pick  = first_set(pick_vec);

	assign empty_entry = '0;

	always_comb begin
		new_entry             = '0;
		new_entry.valid       = 1'b1;
		new_entry.prio        = prio_q;
		new_entry.dest        = dest_q;
		new_entry.number      = preset_q ? pnum_q : 8'd0;
		new_entry.number_set  = preset_q;
		new_entry.timeout     = tmo_q;
		new_entry.retry_limit = maxr_q;
		new_entry.qos         = qos_q;
		new_entry.tag         = tag_q;
	end

	// counter index for every destination code
	for (genvar k = 0; k < 16; k++) begin : g_dmod
		assign dest_mod[k] = NW'(k % NODE_COUNT);
	end

	assign cidx = dest_mod[entries[idx_q].dest];

	always_comb begin
		ctrl.insert  = act_ins_q;
		ctrl.remove  = act_rem_q;
		ctrl.mark    = act_mark_q;
		ctrl.number  = act_num_q;
		ctrl.clear   = act_clr_q;
		ctrl.now     = now_q;
		ctrl.num_val = num_out_q;
	end

	// cell row
	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		logic sel_c, tp, tn;
		assign sel_c = (IW'(g) == idx_q);
		assign tp    = (IW'(g) > idx_q);
		assign tn    = (IW'(g) >= idx_q);
		tprq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.sel        (sel_c),
			.take_prev  (tp),
			.take_next  (tn),
			.new_entry  (new_entry),
			.prev_entry ((g == 0) ? empty_entry : entries[(g == 0) ? 0 : g - 1]),
			.next_entry ((g == QUEUE_DEPTH - 1) ? empty_entry :
				entries[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
			.req_prio   (prio_q),
			.req_dest   (dest_q),
			.req_number (pnum_q),
			.entry      (entries[g]),
			.stat       (stats[g])
		);
	end

	assign req.ready     = (state_q == ST_IDLE);
	assign rsp.valid     = (state_q == ST_OUT);
	assign rsp.ok        = ok_q;
	assign rsp.tag_out   = tag_out_q;
	assign rsp.dest_out  = dest_out_q;
	assign rsp.number_out = num_out_q;
	assign rsp.is_retry  = retry_q;
	assign rsp.dropped   = drop_q;

	// request latch
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_q   <= req.func;
			now_q    <= req.now_ms;
			prio_q   <= req.priority_req;
			dest_q   <= req.dest_id;
			preset_q <= req.number_preset;
			pnum_q   <= req.pkt_number;
			tmo_q    <= req.timeout_ms;
			maxr_q   <= req.max_retry;
			qos_q    <= req.qos;
			tag_q    <= req.tag;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			act_ins_q  <= 1'b0;
			act_rem_q  <= 1'b0;
			act_mark_q <= 1'b0;
			act_num_q  <= 1'b0;
			act_clr_q  <= 1'b0;
			idx_q      <= '0;
			hit_q      <= 1'b0;
			ok_q       <= 1'b0;
			retry_q    <= 1'b0;
			drop_q     <= 1'b0;
			tag_out_q  <= '0;
			dest_out_q <= '0;
			num_out_q  <= '0;
			for (int i = 0; i < NODE_COUNT; i++) begin
				next_number_q[i] <= '0;
			end
		end else begin
			act_ins_q  <= 1'b0;
			act_rem_q  <= 1'b0;
			act_mark_q <= 1'b0;
			act_num_q  <= 1'b0;
			act_clr_q  <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					ok_q       <= 1'b0;
					retry_q    <= 1'b0;
					drop_q     <= 1'b0;
					tag_out_q  <= '0;
					dest_out_q <= '0;
					num_out_q  <= '0;
					state_q    <= ST_ACT;
					case (func_q)
						FUNC_ADD: begin
							if (!v_vec[QUEUE_DEPTH-1]) begin
								idx_q     <= ins_pos[IW-1:0];
								act_ins_q <= 1'b1;
								ok_q      <= 1'b1;
							end
						end
						FUNC_GET: begin
							if (!f_drop[IW]) begin
								idx_q     <= f_drop[IW-1:0];
								act_rem_q <= 1'b1;
								drop_q    <= 1'b1;
							end
							state_q <= ST_DROP;
						end
						FUNC_MARK, FUNC_REMOVE: begin
							if (!f_match[IW]) begin
								idx_q <= f_match[IW-1:0];
								ok_q  <= 1'b1;
								if (func_q == FUNC_MARK && qos_q) begin
									act_mark_q <= 1'b1;
								end else begin
									act_rem_q <= 1'b1;
								end
							end
						end
						FUNC_CLEAR: begin
							act_clr_q <= 1'b1;
							ok_q      <= 1'b1;
						end
						default: begin
						end
					endcase
				end
				ST_DROP: begin
					// cells shift out the dropped entry in this cycle
					state_q <= ST_SEL;
				end
				ST_SEL: begin
					// queue settled after any drop; choose the entry
					hit_q <= !f_pick[IW];
					idx_q <= f_pick[IW-1:0];
					state_q <= ST_ACT;
				end
				ST_ACT: begin
					if (func_q == FUNC_GET && hit_q) begin
						ok_q       <= 1'b1;
						tag_out_q  <= entries[idx_q].tag;
						dest_out_q <= entries[idx_q].dest & DEST_MASK;
						retry_q    <= stats[idx_q].sent;
						if (!stats[idx_q].sent && !entries[idx_q].number_set) begin
							act_num_q  <= 1'b1;
							num_out_q  <= next_number_q[cidx];
							next_number_q[cidx] <= next_number_q[cidx] + 8'd1;
						end else begin
							num_out_q <= entries[idx_q].number;
						end
					end
					hit_q   <= 1'b0;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
